/* rtl/kcs_pkg.sv */
// Shared types, constants and text tables for the keypad calculator sequencer.
// No dependencies; every other file in rtl/ but kcs_div.sv imports this package.
package kcs_pkg;

	// LCD command bytes and characters
	localparam logic [7:0] CMD_CLEAR   = 8'h01;
	localparam logic [7:0] CMD_HOME    = 8'h02;
	localparam logic [7:0] ASCII_ZERO  = 8'h30;
	localparam logic [7:0] ASCII_NINE  = 8'h39;
	localparam logic [7:0] ASCII_MINUS = 8'h2D;

	// keys
	localparam logic [7:0] KEY_PLUS   = 8'h2B;
	localparam logic [7:0] KEY_MINUS  = 8'h2D;
	localparam logic [7:0] KEY_TIMES  = 8'h78;
	localparam logic [7:0] KEY_DIVIDE = 8'h2F;
	localparam logic [7:0] KEY_EQUALS = 8'h3D;
	localparam logic [7:0] KEY_CLEAR  = 8'h43;

	// calculator phases
	localparam logic [1:0] PH_FIRST  = 2'd0;
	localparam logic [1:0] PH_OPER   = 2'd1;
	localparam logic [1:0] PH_SECOND = 2'd2;
	localparam logic [1:0] PH_EQUALS = 2'd3;

	// operator codes
	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_MUL = 2'd2;
	localparam logic [1:0] OP_DIV = 2'd3;

	// error texts, left aligned and padded to sixteen characters
	localparam logic [127:0] TXT_INPUT    = "Wrong Input     ";
	localparam logic [127:0] TXT_FUNCTION = "Wrong Function  ";
	localparam logic [127:0] TXT_DIVZERO  = "Division by zero";

	typedef enum logic [1:0] {
		MSG_INPUT,
		MSG_FUNCTION,
		MSG_DIVZERO
	} msg_sel_t;

	typedef enum logic [2:0] {
		SEL_CLEAR,
		SEL_HOME,
		SEL_ECHO,
		SEL_TEXT,
		SEL_MINUS,
		SEL_TENS,
		SEL_UNITS
	} byte_sel_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LEAD,
		ST_ECHO,
		ST_CLEAR,
		ST_ERR_CLEAR,
		ST_ERR_TEXT,
		ST_ERR_HOME,
		ST_CALC,
		ST_DIV_WAIT,
		ST_SIGN,
		ST_TENS,
		ST_UNITS
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic      load_key;
		logic      emit;
		byte_sel_t sel;
		logic      last;
		logic      advance;
		logic      phase_clr;
		logic      msg_load;
		msg_sel_t  msg_sel;
		logic      msg_inc;
		logic      calc;
		logic      div_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [1:0] phase;
		logic       key_digit;
		logic       key_oper;
		logic       key_equals;
		logic       key_clear;
		logic       op_div;
		logic       div_zero;
		logic       res_neg;
		logic       tens_nz;
		logic       msg_end;
		logic       div_done;
		logic       out_free;
	} status_t;

	function automatic logic [7:0] msg_char(msg_sel_t sel, logic [3:0] idx);
		logic [127:0] txt;
		logic [6:0]   pos;
		case (sel)
			MSG_INPUT:    txt = TXT_INPUT;
			MSG_FUNCTION: txt = TXT_FUNCTION;
			MSG_DIVZERO:  txt = TXT_DIVZERO;
			default:      txt = TXT_INPUT;
		endcase
		pos = {~idx, 3'b000};
		return txt[pos +: 8];
	endfunction

	function automatic logic [3:0] msg_last(msg_sel_t sel);
		case (sel)
			MSG_INPUT:    return 4'd10;
			MSG_FUNCTION: return 4'd13;
			MSG_DIVZERO:  return 4'd15;
			default:      return 4'd10;
		endcase
	endfunction

endpackage

/* rtl/keypad_calculator_sequencer.sv */
// Top level of the single-digit keypad calculator sequencer.
// Depends on kcs_pkg, kcs_ctrl, kcs_datapath (and kcs_div below it).
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+---------------------------
//   key in  | key_valid | key_stall | key
//   lcd out | lcd_valid | lcd_stall | is_data, lcd_byte, last
//
// One key is worked at a time: the controller accepts it in ST_IDLE, then
// sends its display bytes (1 to 19 bytes), held while lcd_stall is high.
// A result passes ST_CALC for the arithmetic and then ST_SIGN, ST_TENS and
// ST_UNITS, the sign and tens printed only when needed; a quotient also waits
// in ST_DIV_WAIT on the bit-serial divider between ST_CALC and ST_SIGN.
// arst_n clears the controller, the phase and the output valid at once.
// lcd_stall holds the byte sequencer; a new key is taken while the final
// byte of the previous run still waits in the output register.
module keypad_calculator_sequencer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       key_valid,
	output logic       key_stall,
	input  logic [7:0] key,
	output logic       lcd_valid,
	input  logic       lcd_stall,
	output logic       is_data,
	output logic [7:0] lcd_byte,
	output logic       last
);

	import kcs_pkg::*;

	cmd_t    cmd;
	status_t status;

	// sequence the bytes of each transaction
	kcs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.key_valid (key_valid),
		.key_stall (key_stall),
		.status    (status),
		.cmd       (cmd)
	);

	// hold the calculator state, compute the result, drive the output register
	kcs_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.key       (key),
		.cmd       (cmd),
		.status    (status),
		.lcd_stall (lcd_stall),
		.lcd_valid (lcd_valid),
		.is_data   (is_data),
		.lcd_byte  (lcd_byte),
		.last      (last)
	);

`ifndef NO_ASSERTIONS
	// an accepted key always starts a run: the input closes the next cycle
	a_accept_closes: assert property (@(posedge clk) disable iff (!arst_n)
		key_valid && !key_stall |=> key_stall)
		else $error("key input still open after a transaction");

	// the input reopens only after the final byte of the run was loaded
	a_reopen_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(key_stall) |-> $past(cmd.emit && cmd.last && status.out_free))
		else $error("key input reopened before the final byte");

	// a loaded byte shows up on the output
	a_emit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit && status.out_free |=> lcd_valid)
		else $error("emitted byte did not reach the output register");

	// the divider only finishes for a divide
	a_div_only: assert property (@(posedge clk) disable iff (!arst_n)
		status.div_done |-> status.op_div)
		else $error("divider finished without a divide operator");
`endif

endmodule

/* rtl/kcs_div.sv */
// Four-bit restoring divider, one quotient bit per cycle.
// Depends on kcs_pkg only by convention; uses no package items.
module kcs_div (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [3:0] dividend,
	input  logic [3:0] divisor,
	output logic       done,
	output logic [3:0] quotient
);

	logic       busy_q;
	logic       done_q;
	logic [1:0] cnt_q;
	logic [3:0] rem_q;
	logic [3:0] quo_q;
	logic [4:0] trial;
	logic [4:0] diff;
	logic       fits;

	assign trial = {rem_q, quo_q[3]};
	assign diff  = trial - {1'b0, divisor};
	assign fits  = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 2'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= 4'd0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? diff[3:0] : trial[3:0];
			quo_q <= {quo_q[2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

/* rtl/kcs_datapath.sv */
// Datapath: key, calculator state, result arithmetic, text index and output register.
// Depends on kcs_pkg and kcs_div.
module kcs_datapath (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [7:0]       key,
	input  kcs_pkg::cmd_t    cmd,
	output kcs_pkg::status_t status,
	input  logic             lcd_stall,
	output logic             lcd_valid,
	output logic             is_data,
	output logic [7:0]       lcd_byte,
	output logic             last
);

	import kcs_pkg::*;

	logic [7:0]  key_q;
	logic [1:0]  phase_q;
	logic [3:0]  first_q;
	logic [1:0]  op_q;
	logic [3:0]  second_q;
	msg_sel_t    msg_sel_q;
	logic [3:0]  msg_idx_q;
	logic        neg_q;
	logic [6:0]  mag_q;
	logic        valid_q;
	logic        is_data_q;
	logic [7:0]  byte_q;
	logic        last_q;

	logic [1:0]  key_op_code;
	logic        div_start;
	logic        div_done;
	logic [3:0]  quotient;
	logic [7:0]  product;
	logic [14:0] tens_prod;
	logic [3:0]  tens;
	logic [6:0]  tens_x10;
	logic [6:0]  units_full;
	logic [3:0]  units;
	logic        out_free;
	logic [7:0]  next_byte;
	logic        next_is_data;

	// key decode
	always_comb begin
		case (key_q)
			KEY_PLUS:  key_op_code = OP_ADD;
			KEY_MINUS: key_op_code = OP_SUB;
			KEY_TIMES: key_op_code = OP_MUL;
			default:   key_op_code = OP_DIV;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load_key)
			key_q <= key;
	end

	// calculator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_FIRST;
			first_q  <= 4'd0;
			op_q     <= OP_ADD;
			second_q <= 4'd0;
		end else if (cmd.advance) begin
			case (phase_q)
				PH_FIRST: begin
					first_q <= key_q[3:0];
					phase_q <= PH_OPER;
				end
				PH_OPER: begin
					op_q    <= key_op_code;
					phase_q <= PH_SECOND;
				end
				PH_SECOND: begin
					second_q <= key_q[3:0];
					phase_q  <= PH_EQUALS;
				end
				default: phase_q <= PH_FIRST;
			endcase
		end else if (cmd.phase_clr) begin
			phase_q <= PH_FIRST;
		end
	end

	// error text pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msg_sel_q <= MSG_INPUT;
			msg_idx_q <= 4'd0;
		end else if (cmd.msg_load) begin
			msg_sel_q <= cmd.msg_sel;
			msg_idx_q <= 4'd0;
		end else if (cmd.msg_inc) begin
			msg_idx_q <= msg_idx_q + 4'd1;
		end
	end

	// arithmetic
	assign div_start = cmd.calc && (op_q == OP_DIV);
	assign product   = {4'd0, first_q} * {4'd0, second_q};

	kcs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (first_q),
		.divisor  (second_q),
		.done     (div_done),
		.quotient (quotient)
	);

	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			case (op_q)
				OP_ADD: begin
					neg_q <= 1'b0;
					mag_q <= {3'd0, first_q} + {3'd0, second_q};
				end
				OP_SUB: begin
					neg_q <= first_q < second_q;
					mag_q <= (first_q < second_q) ? {3'd0, second_q - first_q}
					                              : {3'd0, first_q - second_q};
				end
				OP_MUL: begin
					neg_q <= 1'b0;
					mag_q <= product[6:0];
				end
				default: ;
			endcase
		end else if (cmd.div_load) begin
			neg_q <= 1'b0;
			mag_q <= {3'd0, quotient};
		end
	end

	// tens by reciprocal, exact for magnitudes below 1029
	assign tens_prod  = {8'd0, mag_q} * 15'd205;
	assign tens       = tens_prod[14:11];
	assign tens_x10   = {tens, 3'b000} + {2'b00, tens, 1'b0};
	assign units_full = mag_q - tens_x10;
	assign units      = units_full[3:0];

	// byte select
	always_comb begin
		next_is_data = 1'b1;
		case (cmd.sel)
			SEL_CLEAR: begin
				next_byte    = CMD_CLEAR;
				next_is_data = 1'b0;
			end
			SEL_HOME: begin
				next_byte    = CMD_HOME;
				next_is_data = 1'b0;
			end
			SEL_ECHO:  next_byte = key_q;
			SEL_TEXT:  next_byte = msg_char(msg_sel_q, msg_idx_q);
			SEL_MINUS: next_byte = ASCII_MINUS;
			SEL_TENS:  next_byte = ASCII_ZERO + {4'd0, tens};
			SEL_UNITS: next_byte = ASCII_ZERO + {4'd0, units};
			default:   next_byte = key_q;
		endcase
	end

	// output register
	assign out_free = !valid_q || !lcd_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (cmd.emit && out_free)
			valid_q <= 1'b1;
		else if (!lcd_stall)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit && out_free) begin
			is_data_q <= next_is_data;
			byte_q    <= next_byte;
			last_q    <= cmd.last;
		end
	end

	assign lcd_valid = valid_q;
	assign is_data   = is_data_q;
	assign lcd_byte  = byte_q;
	assign last      = last_q;

	// status
	assign status.phase      = phase_q;
	assign status.key_digit  = key_q inside {[ASCII_ZERO:ASCII_NINE]};
	assign status.key_oper   = key_q inside {KEY_PLUS, KEY_MINUS, KEY_TIMES, KEY_DIVIDE};
	assign status.key_equals = key_q == KEY_EQUALS;
	assign status.key_clear  = key_q == KEY_CLEAR;
	assign status.op_div     = op_q == OP_DIV;
	assign status.div_zero   = second_q == 4'd0;
	assign status.res_neg    = neg_q;
	assign status.tens_nz    = tens != 4'd0;
	assign status.msg_end    = msg_idx_q == msg_last(msg_sel_q);
	assign status.div_done   = div_done;
	assign status.out_free   = out_free;

endmodule

/* rtl/kcs_ctrl.sv */
// Controller state machine: sequences the display bytes of one key.
// Depends on kcs_pkg.
module kcs_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             key_valid,
	output logic             key_stall,
	input  kcs_pkg::status_t status,
	output kcs_pkg::cmd_t    cmd
);

	import kcs_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   advance;
	logic   fire;
	logic   div_error;

	// a key that moves the calculation forward ends its run with the echo
	assign advance = ((status.phase == PH_FIRST || status.phase == PH_SECOND)
	                  && status.key_digit)
	              || (status.phase == PH_OPER && status.key_oper);
	assign div_error = status.phase == PH_EQUALS && status.key_equals
	                && status.op_div && status.div_zero;
	assign fire = cmd.emit && status.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (key_valid)
					state_d = (status.phase == PH_FIRST) ? ST_LEAD : ST_ECHO;
			end
			ST_LEAD: begin
				if (fire)
					state_d = ST_ECHO;
			end
			ST_ECHO: begin
				if (fire) begin
					if (advance)
						state_d = ST_IDLE;
					else if (status.key_clear)
						state_d = ST_CLEAR;
					else if (status.phase == PH_EQUALS && status.key_equals && !div_error)
						state_d = ST_CALC;
					else
						state_d = ST_ERR_CLEAR;
				end
			end
			ST_CLEAR: begin
				if (fire)
					state_d = ST_IDLE;
			end
			ST_ERR_CLEAR: begin
				if (fire)
					state_d = ST_ERR_TEXT;
			end
			ST_ERR_TEXT: begin
				if (fire && status.msg_end)
					state_d = ST_ERR_HOME;
			end
			ST_ERR_HOME: begin
				if (fire)
					state_d = ST_IDLE;
			end
			ST_CALC: begin
				state_d = status.op_div ? ST_DIV_WAIT : ST_SIGN;
			end
			ST_DIV_WAIT: begin
				if (status.div_done)
					state_d = ST_SIGN;
			end
			ST_SIGN: begin
				if (!status.res_neg || fire)
					state_d = ST_TENS;
			end
			ST_TENS: begin
				if (!status.tens_nz || fire)
					state_d = ST_UNITS;
			end
			ST_UNITS: begin
				if (fire)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.load_key  = 1'b0;
		cmd.emit      = 1'b0;
		cmd.sel       = SEL_ECHO;
		cmd.last      = 1'b0;
		cmd.advance   = 1'b0;
		cmd.phase_clr = 1'b0;
		cmd.msg_load  = 1'b0;
		cmd.msg_sel   = MSG_INPUT;
		cmd.msg_inc   = 1'b0;
		cmd.calc      = 1'b0;
		cmd.div_load  = 1'b0;
		key_stall     = 1'b1;
		case (state_q)
			ST_IDLE: begin
				key_stall    = 1'b0;
				cmd.load_key = key_valid;
			end
			ST_LEAD: begin
				cmd.emit = 1'b1;
				cmd.sel  = SEL_CLEAR;
			end
			ST_ECHO: begin
				cmd.emit      = 1'b1;
				cmd.sel       = SEL_ECHO;
				cmd.last      = advance;
				cmd.advance   = status.out_free && advance;
				cmd.phase_clr = status.out_free && !advance;
				cmd.msg_load  = status.out_free;
				if (status.phase == PH_OPER)
					cmd.msg_sel = MSG_FUNCTION;
				else if (div_error)
					cmd.msg_sel = MSG_DIVZERO;
				else
					cmd.msg_sel = MSG_INPUT;
			end
			ST_CLEAR: begin
				cmd.emit = 1'b1;
				cmd.sel  = SEL_CLEAR;
				cmd.last = 1'b1;
			end
			ST_ERR_CLEAR: begin
				cmd.emit = 1'b1;
				cmd.sel  = SEL_CLEAR;
			end
			ST_ERR_TEXT: begin
				cmd.emit    = 1'b1;
				cmd.sel     = SEL_TEXT;
				cmd.msg_inc = status.out_free;
			end
			ST_ERR_HOME: begin
				cmd.emit = 1'b1;
				cmd.sel  = SEL_HOME;
				cmd.last = 1'b1;
			end
			ST_CALC: begin
				cmd.calc = 1'b1;
			end
			ST_DIV_WAIT: begin
				cmd.div_load = status.div_done;
			end
			ST_SIGN: begin
				cmd.emit = status.res_neg;
				cmd.sel  = SEL_MINUS;
			end
			ST_TENS: begin
				cmd.emit = status.tens_nz;
				cmd.sel  = SEL_TENS;
			end
			ST_UNITS: begin
				cmd.emit = 1'b1;
				cmd.sel  = SEL_UNITS;
				cmd.last = 1'b1;
			end
			default: ;
		endcase
	end

endmodule

/* test/tb_top.sv */
// Self-checking bench for keypad_calculator_sequencer: feeds key codes with random gaps
// and checks every LCD byte against a calculator model that runs inside the bench.
// Depends on kcs_pkg and the RTL top level; needs no files or arguments.
import kcs_pkg::*;

typedef struct packed {
	logic       is_data;
	logic [7:0] value;
	logic       last;
} lcd_beat_t;

// Tracks the calculator state and holds the LCD bytes each key should produce.
class calc_scoreboard;
	logic [1:0] phase;
	logic [3:0] first_digit;
	logic [1:0] op;
	logic [3:0] second_digit;
	lcd_beat_t  lcd_pending[$];
	int         keys_seen;
	int         beats_seen;
	int         mismatches;
	int         results;
	int         error_lines;
	int         clears;

	function new();
		phase = PH_FIRST;
		first_digit = 4'd0;
		op = OP_ADD;
		second_digit = 4'd0;
		keys_seen = 0;
		beats_seen = 0;
		mismatches = 0;
		results = 0;
		error_lines = 0;
		clears = 0;
	endfunction

	function int pending();
		return lcd_pending.size();
	endfunction

	function void add_beat(logic d, logic [7:0] v);
		lcd_beat_t b;
		b.is_data = d;
		b.value = v;
		b.last = 1'b0;
		lcd_pending.push_back(b);
	endfunction

	function void add_error(string text);
		add_beat(1'b0, CMD_CLEAR);
		for (int i = 0; i < text.len(); i++)
			add_beat(1'b1, text[i]);
		add_beat(1'b0, CMD_HOME);
		error_lines++;
	endfunction

	function void add_clear();
		add_beat(1'b0, CMD_CLEAR);
		clears++;
	endfunction

	// Predict the LCD run of one accepted key and advance the phase.
	function void note_key(logic [7:0] k);
		int        a;
		int        b;
		int        r;
		int        mag;
		bit        is_dig;
		lcd_beat_t tail;
		keys_seen++;
		is_dig = (k >= ASCII_ZERO) && (k <= ASCII_NINE);
		if (phase == PH_FIRST)
			add_beat(1'b0, CMD_CLEAR);
		add_beat(1'b1, k);
		case (phase)
		PH_FIRST, PH_SECOND: begin
			if (is_dig) begin
				// low nibble of an ASCII digit is its value
				if (phase == PH_FIRST) begin
					first_digit = k[3:0];
					phase = PH_OPER;
				end else begin
					second_digit = k[3:0];
					phase = PH_EQUALS;
				end
			end else begin
				if (k == KEY_CLEAR)
					add_clear();
				else
					add_error("Wrong Input");
				phase = PH_FIRST;
			end
		end
		PH_OPER: begin
			case (k)
			KEY_PLUS: begin
				op = OP_ADD;
				phase = PH_SECOND;
			end
			KEY_MINUS: begin
				op = OP_SUB;
				phase = PH_SECOND;
			end
			KEY_TIMES: begin
				op = OP_MUL;
				phase = PH_SECOND;
			end
			KEY_DIVIDE: begin
				op = OP_DIV;
				phase = PH_SECOND;
			end
			KEY_CLEAR: begin
				add_clear();
				phase = PH_FIRST;
			end
			default: begin
				add_error("Wrong Function");
				phase = PH_FIRST;
			end
			endcase
		end
		default: begin
			if (k == KEY_EQUALS) begin
				a = first_digit;
				b = second_digit;
				if (op == OP_DIV && b == 0) begin
					add_error("Division by zero");
				end else begin
					case (op)
					OP_ADD: r = a + b;
					OP_SUB: r = a - b;
					OP_MUL: r = a * b;
					default: r = a / b;
					endcase
					results++;
					if (r < 0)
						add_beat(1'b1, ASCII_MINUS);
					mag = (r < 0) ? -r : r;
					if (mag / 10 != 0)
						add_beat(1'b1, ASCII_ZERO + 8'(mag / 10));
					add_beat(1'b1, ASCII_ZERO + 8'(mag % 10));
				end
			end else if (k == KEY_CLEAR) begin
				add_clear();
			end else begin
				add_error("Wrong Input");
			end
			phase = PH_FIRST;
		end
		endcase
		// flag the final byte of this key's run
		tail = lcd_pending.pop_back();
		tail.last = 1'b1;
		lcd_pending.push_back(tail);
	endfunction

	// Compare one accepted LCD byte with the oldest expected one.
	function void check_byte(logic d, logic [7:0] v, logic l);
		lcd_beat_t want;
		beats_seen++;
		if (lcd_pending.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("MISMATCH @%0t: unexpected byte is_data=%0b byte=%02h last=%0b",
					$time, d, v, l);
		end else begin
			want = lcd_pending.pop_front();
			if (want.is_data !== d || want.value !== v || want.last !== l) begin
				mismatches++;
				if (mismatches <= 10)
					$display("MISMATCH @%0t: want is_data=%0b byte=%02h last=%0b, got %0b %02h %0b",
						$time, want.is_data, want.value, want.last, d, v, l);
			end
		end
	endfunction
endclass

module tb_top;
	localparam int N_DIRECTED  = 30;
	localparam int RANDOM_KEYS = 330;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       key_valid = 1'b0;
	logic       key_stall;
	logic [7:0] key = 8'h00;
	logic       lcd_valid;
	logic       lcd_stall = 1'b0;
	logic       is_data;
	logic [7:0] lcd_byte;
	logic       last;

	// long receiver hold-off, raised by the pressure process
	logic hold_req = 1'b0;
	// both sides run back to back while this is set
	logic no_gaps = 1'b0;

	logic [7:0] directed_keys [N_DIRECTED];
	calc_scoreboard sb;

	keypad_calculator_sequencer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.key_valid (key_valid),
		.key_stall (key_stall),
		.key       (key),
		.lcd_valid (lcd_valid),
		.lcd_stall (lcd_stall),
		.is_data   (is_data),
		.lcd_byte  (lcd_byte),
		.last      (last)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Draw the idle cycles before a transaction; zero often, so back-to-back
	// traffic shows up on both channels.
	function automatic int draw_gap();
		if (no_gaps || $urandom_range(0, 4) == 0)
			return 0;
		return $urandom_range(0, 13);
	endfunction

	function automatic logic [7:0] random_digit();
		return ASCII_ZERO + 8'($urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] random_oper();
		logic [7:0] k;
		case ($urandom_range(0, 3))
		0: k = KEY_PLUS;
		1: k = KEY_MINUS;
		2: k = KEY_TIMES;
		default: k = KEY_DIVIDE;
		endcase
		return k;
	endfunction

	// Any byte at all, with a bias toward the clear key.
	function automatic logic [7:0] random_noise();
		if ($urandom_range(0, 4) == 0)
			return KEY_CLEAR;
		return 8'($urandom_range(0, 255));
	endfunction

	// Offer one key and hold it until the block takes it. Valid stays high
	// across back-to-back keys; only the payload changes then.
	task automatic send_key(input logic [7:0] k);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			key_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		key_valid <= 1'b1;
		key <= k;
		do
			@(posedge clk);
		while (key_stall);
		sb.note_key(k);
	endtask

	// Send a full digit-operator-digit-equals sequence, sometimes cut short
	// or finished with a clear or a stray key.
	task automatic send_calculation();
		int shape;
		if (sb.phase != PH_FIRST)
			send_key(KEY_CLEAR);
		shape = $urandom_range(0, 11);
		send_key(random_digit());
		if (shape == 0) begin
			send_key(random_noise());
		end else begin
			send_key(random_oper());
			if (shape == 1) begin
				send_key(random_noise());
			end else begin
				send_key(random_digit());
				case (shape)
				2: send_key(KEY_CLEAR);
				3: send_key(random_noise());
				default: send_key(KEY_EQUALS);
				endcase
			end
		end
	endtask

	// LCD side: draw a stall per byte, honor the long hold-off, then take
	// the next byte and hand it to the scoreboard.
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			gap = draw_gap();
			if (gap > 0 || hold_req) begin
				lcd_stall <= 1'b1;
				repeat (gap) @(posedge clk);
				while (hold_req)
					@(posedge clk);
			end
			lcd_stall <= 1'b0;
			do
				@(posedge clk);
			while (!lcd_valid);
			sb.check_byte(is_data, lcd_byte, last);
		end
	end

	// Hold the display side off twice for a long stretch while keys keep
	// coming, so the block backs up and stalls its key input.
	initial begin
		@(posedge arst_n);
		while (sb.keys_seen < 80)
			@(posedge clk);
		hold_req <= 1'b1;
		repeat (400) @(posedge clk);
		hold_req <= 1'b0;
		while (sb.keys_seen < 280)
			@(posedge clk);
		hold_req <= 1'b1;
		repeat (300) @(posedge clk);
		hold_req <= 1'b0;
	end

	// Main sequence: reset, directed keys, random keys, drain, verdict.
	initial begin
		sb = new();
		// extremes of the key, each operator, negative and two-digit
		// results, division by zero, each error path and a clear in the first and second phases
		directed_keys = '{8'h00,
			"9", KEY_TIMES, "9", KEY_EQUALS,
			"0", KEY_MINUS, "9", KEY_EQUALS,
			"9", KEY_DIVIDE, "0", KEY_EQUALS,
			"7", KEY_DIVIDE, "2", KEY_EQUALS,
			"6", KEY_PLUS, 8'hFF,
			"5", 8'h80,
			"1", KEY_PLUS, KEY_CLEAR,
			KEY_CLEAR,
			"2", KEY_MINUS, "3", "A"};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_keys[i])
			send_key(directed_keys[i]);

		while (sb.keys_seen < N_DIRECTED + RANDOM_KEYS) begin
			// run a stretch with no idling on either side
			no_gaps = (sb.keys_seen >= N_DIRECTED + 150) && (sb.keys_seen < N_DIRECTED + 200);
			if ($urandom_range(0, 4) == 0)
				send_key(random_noise());
			else
				send_calculation();
		end
		no_gaps = 1'b0;
		key_valid <= 1'b0;

		// drain, then watch a little longer for stray bytes
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("Covered %0d keys and %0d LCD bytes: %0d results, %0d error lines, %0d clears.",
			sb.keys_seen, sb.beats_seen, sb.results, sb.error_lines, sb.clears);
		$display("Mismatches: %0d, bytes still expected: %0d", sb.mismatches, sb.pending());
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#8000000;
		$display("Timeout: run did not finish");
		$display("RESULT: ERROR");
		$finish;
	end
endmodule

/* sim.f */
rtl/kcs_pkg.sv
rtl/kcs_div.sv
rtl/kcs_datapath.sv
rtl/kcs_ctrl.sv
rtl/keypad_calculator_sequencer.sv
test/tb_top.sv
